### hdl/mta_pkg.sv
package mta_pkg;

    // vertex store depth and index width
    localparam int VERTEX_COUNT = 1024;
    localparam int IDX_W        = 10;
    localparam int ADDR_W       = $clog2(VERTEX_COUNT);

    // field and sum widths
    localparam int POS_W = 32;
    localparam int TEX_W = 16;
    localparam int SUM_W = 48;
    localparam int OUT_W = 16;

    // shared divider: 71-bit dividend, 36-bit divisor
    localparam int DIV_NUM_W = 71;
    localparam int DIV_DEN_W = 36;

    // operation codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // largest sum magnitude, 2^47-1
    localparam logic [SUM_W-2:0] SUM_MAG_MAX = {(SUM_W-1){1'b1}};

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
    } t_geo;

    typedef struct packed {
        logic signed [SUM_W-1:0] tx;
        logic signed [SUM_W-1:0] ty;
        logic signed [SUM_W-1:0] tz;
        logic signed [SUM_W-1:0] bx;
        logic signed [SUM_W-1:0] by;
        logic signed [SUM_W-1:0] bz;
    } t_sums;

    localparam int GEO_W  = $bits(t_geo);
    localparam int SUMS_W = $bits(t_sums);

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(VERTEX_COUNT));
    endfunction

    // saturating add; bit SUM_W flags a clamp
    function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] == s[SUM_W-1]) begin
            return {1'b0, s[SUM_W-1:0]};
        end else if (s[SUM_W]) begin
            return {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, SUM_MAG_MAX};
        end
    endfunction

endpackage

### hdl/mta_ram.sv
module mta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mta_div.sv
module mta_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mta_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [mta_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [mta_pkg::DIV_NUM_W-1:0] o_quot
);
    import mta_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // one restoring step: bring in the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[DIV_NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = !diff[DIV_DEN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### hdl/mesh_tangent_accumulator_top.sv
// Per-vertex tangent/bitangent accumulator. Vertex geometry and the six
// Q24.24 sums live in two single-write, registered-read RAMs. After reset
// a clearing pass zeroes the sum RAM, one entry per cycle; no item is
// taken until it ends. A triangle reads its three corners, then runs six
// quotients through one shared restoring divider (one bit a cycle) and
// does three read-modify-write passes on the sum RAM. A read runs, for
// each vector, a shift normalizer, a 32-step square root and three
// divider passes. One item is worked on at a time; a finished result
// waits in an output register while the next is taken.
module mesh_tangent_accumulator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic [mta_pkg::IDX_W-1:0]          i_index_a,
    input  logic [mta_pkg::IDX_W-1:0]          i_index_b,
    input  logic [mta_pkg::IDX_W-1:0]          i_index_c,
    input  logic signed [mta_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [mta_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [mta_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [mta_pkg::TEX_W-1:0]   i_tex_u,
    input  logic signed [mta_pkg::TEX_W-1:0]   i_tex_v,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_status,
    output logic signed [mta_pkg::OUT_W-1:0]   o_tangent_x,
    output logic signed [mta_pkg::OUT_W-1:0]   o_tangent_y,
    output logic signed [mta_pkg::OUT_W-1:0]   o_tangent_z,
    output logic signed [mta_pkg::OUT_W-1:0]   o_bitangent_x,
    output logic signed [mta_pkg::OUT_W-1:0]   o_bitangent_y,
    output logic signed [mta_pkg::OUT_W-1:0]   o_bitangent_z
);
    import mta_pkg::*;

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_GA    = 5'd2;
    localparam logic [4:0] S_GB    = 5'd3;
    localparam logic [4:0] S_GC    = 5'd4;
    localparam logic [4:0] S_GD    = 5'd5;
    localparam logic [4:0] S_DLT   = 5'd6;
    localparam logic [4:0] S_DETM  = 5'd7;
    localparam logic [4:0] S_DETS  = 5'd8;
    localparam logic [4:0] S_NUMM  = 5'd9;
    localparam logic [4:0] S_NUMS  = 5'd10;
    localparam logic [4:0] S_QS    = 5'd11;
    localparam logic [4:0] S_QW    = 5'd12;
    localparam logic [4:0] S_AR    = 5'd13;
    localparam logic [4:0] S_AW    = 5'd14;
    localparam logic [4:0] S_RR    = 5'd15;
    localparam logic [4:0] S_RC    = 5'd16;
    localparam logic [4:0] S_NLD   = 5'd17;
    localparam logic [4:0] S_NSH   = 5'd18;
    localparam logic [4:0] S_NSQ   = 5'd19;
    localparam logic [4:0] S_NSS   = 5'd20;
    localparam logic [4:0] S_SQ    = 5'd21;
    localparam logic [4:0] S_NDS   = 5'd22;
    localparam logic [4:0] S_NDW   = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    localparam int SQ_W = 64;
    localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << 62;

    // control
    logic [4:0]        r_state;
    logic [ADDR_W-1:0] r_clr;
    logic              r_out_valid;
    logic [1:0]        r_k;
    logic              r_qsel;
    logic              r_vsel;

    // item
    logic [IDX_W-1:0]  r_ia, r_ib, r_ic;
    logic [1:0]        r_status;
    logic              r_sat;
    logic              r_zero;

    // triangle datapath
    t_geo                  r_ga, r_gb, r_gc;
    logic signed [16:0]    r_du1, r_dv1, r_du2, r_dv2;
    logic signed [32:0]    r_e1 [3];
    logic signed [32:0]    r_e2 [3];
    logic signed [34:0]    r_pd1, r_pd2;
    logic signed [35:0]    r_det;
    logic signed [49:0]    r_p1, r_p2, r_p3, r_p4;
    logic signed [50:0]    r_num_t, r_num_b;
    logic                  r_qsat, r_qneg;
    logic [SUM_W-1:0]      r_t [3];
    logic [SUM_W-1:0]      r_b [3];

    // read datapath
    t_sums                 r_sums;
    logic [SUM_W-1:0]      r_na [3];
    logic                  r_nneg [3];
    logic [59:0]           r_sq [3];
    logic [SQ_W-1:0]       r_sn, r_sres, r_sbit;
    logic [OUT_W-1:0]      r_vec [6];

    // output register
    logic [1:0]            r_o_status;
    logic [OUT_W-1:0]      r_o_vec [6];

    // memories and divider
    logic                  geo_we;
    logic [ADDR_W-1:0]     geo_waddr, geo_raddr;
    t_geo                  geo_wdata, geo_rdata;
    logic                  sum_we;
    logic [ADDR_W-1:0]     sum_waddr, sum_raddr;
    t_sums                 sum_wdata, sum_rdata;
    logic                  div_start, div_done;
    logic [DIV_NUM_W-1:0]  div_num, div_quot;
    logic [DIV_DEN_W-1:0]  div_den;

    logic                  in_xfer, out_load;
    logic [IDX_W-1:0]      corner;
    logic signed [32:0]    e1k, e2k;
    logic signed [50:0]    qnum;
    logic [50:0]           an;
    logic [35:0]           ad;
    logic                  qsat;
    logic [SUM_W:0]        acc [6];
    logic [SUM_W-1:0]      vsrc [3];
    logic                  sh_hi, sh_lo;
    logic [SQ_W-1:0]       sq_try;
    logic [30:0]           len;
    logic [44:0]           nd_num;
    logic [46:0]           qmag;
    logic [14:0]           nq;
    logic [2:0]            vidx;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // corner and component selection
    always_comb begin
        unique case (r_k)
            2'd0:    corner = r_ia;
            2'd1:    corner = r_ib;
            default: corner = r_ic;
        endcase
        e1k = r_e1[r_k];
        e2k = r_e2[r_k];
    end

    // quotient operands and clamp test
    always_comb begin
        qnum = r_qsel ? r_num_b : r_num_t;
        an   = qnum[50] ? (51'd0 - qnum) : qnum;
        ad   = r_det[35] ? (36'd0 - r_det) : r_det;
        qsat = ({12'd0, an} >= {ad, 27'd0});
        qmag = r_qsat ? SUM_MAG_MAX : div_quot[46:0];
    end

    // accumulation with saturation
    always_comb begin
        acc[0] = sat_add(sum_rdata.tx, r_t[0]);
        acc[1] = sat_add(sum_rdata.ty, r_t[1]);
        acc[2] = sat_add(sum_rdata.tz, r_t[2]);
        acc[3] = sat_add(sum_rdata.bx, r_b[0]);
        acc[4] = sat_add(sum_rdata.by, r_b[1]);
        acc[5] = sat_add(sum_rdata.bz, r_b[2]);
    end

    // normalizer helpers
    always_comb begin
        if (r_vsel) begin
            vsrc[0] = r_sums.bx;
            vsrc[1] = r_sums.by;
            vsrc[2] = r_sums.bz;
        end else begin
            vsrc[0] = r_sums.tx;
            vsrc[1] = r_sums.ty;
            vsrc[2] = r_sums.tz;
        end
        sh_hi  = (|r_na[0][SUM_W-1:30]) || (|r_na[1][SUM_W-1:30])
              || (|r_na[2][SUM_W-1:30]);
        sh_lo  = !((|r_na[0][SUM_W-1:29]) || (|r_na[1][SUM_W-1:29])
              || (|r_na[2][SUM_W-1:29]));
        sq_try = r_sres + r_sbit;
        len    = r_sres[30:0];
        nd_num = {r_na[r_k][29:0], 14'd0} + 45'(len >> 1);
        nq     = div_quot[14:0];
        vidx   = {1'b0, r_k} + (r_vsel ? 3'd3 : 3'd0);
    end

    // divider operand select
    always_comb begin
        div_start = (r_state == S_QS) || (r_state == S_NDS);
        if (r_state == S_NDS) begin
            div_num = DIV_NUM_W'(nd_num);
            div_den = DIV_DEN_W'(len);
        end else begin
            div_num = {an, 20'd0};
            div_den = ad;
        end
    end

    // memory ports
    always_comb begin
        geo_we          = in_xfer && (i_operation == OP_LOAD) && in_range(i_index_a);
        geo_waddr       = i_index_a[ADDR_W-1:0];
        geo_wdata.px    = i_pos_x;
        geo_wdata.py    = i_pos_y;
        geo_wdata.pz    = i_pos_z;
        geo_wdata.u     = i_tex_u;
        geo_wdata.v     = i_tex_v;
        unique case (r_state)
            S_GB:    geo_raddr = r_ib[ADDR_W-1:0];
            S_GC:    geo_raddr = r_ic[ADDR_W-1:0];
            default: geo_raddr = r_ia[ADDR_W-1:0];
        endcase

        sum_we    = 1'b0;
        sum_waddr = i_index_a[ADDR_W-1:0];
        sum_wdata = '0;
        priority if (r_state == S_CLEAR) begin
            sum_we    = 1'b1;
            sum_waddr = r_clr;
        end else if (geo_we) begin
            sum_we    = 1'b1;
        end else if (r_state == S_AW) begin
            sum_we       = 1'b1;
            sum_waddr    = corner[ADDR_W-1:0];
            sum_wdata.tx = acc[0][SUM_W-1:0];
            sum_wdata.ty = acc[1][SUM_W-1:0];
            sum_wdata.tz = acc[2][SUM_W-1:0];
            sum_wdata.bx = acc[3][SUM_W-1:0];
            sum_wdata.by = acc[4][SUM_W-1:0];
            sum_wdata.bz = acc[5][SUM_W-1:0];
        end
        sum_raddr = (r_state == S_AR) ? corner[ADDR_W-1:0] : r_ia[ADDR_W-1:0];
    end

    mta_ram #(.WIDTH(GEO_W), .DEPTH(VERTEX_COUNT)) u_geo_ram (
        .i_clk   (i_clk),
        .i_we    (geo_we),
        .i_waddr (geo_waddr),
        .i_wdata (geo_wdata),
        .i_raddr (geo_raddr),
        .o_rdata (geo_rdata)
    );

    mta_ram #(.WIDTH(SUMS_W), .DEPTH(VERTEX_COUNT)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    mta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_qsel      <= 1'b0;
            r_vsel      <= 1'b0;
        end else begin
            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_o_status  <= r_status;
                for (int i = 0; i < 6; i++) r_o_vec[i] <= r_vec[i];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(VERTEX_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ia     <= i_index_a;
                        r_ib     <= i_index_b;
                        r_ic     <= i_index_c;
                        r_sat    <= 1'b0;
                        r_zero   <= 1'b0;
                        r_k      <= '0;
                        r_qsel   <= 1'b0;
                        r_vsel   <= 1'b0;
                        r_status <= ST_OK;
                        for (int i = 0; i < 6; i++) r_vec[i] <= '0;
                        unique case (i_operation)
                            OP_TRI: begin
                                if (in_range(i_index_a) && in_range(i_index_b)
                                        && in_range(i_index_c)) begin
                                    r_state <= S_GA;
                                end else begin
                                    r_status <= ST_DEGEN;
                                    r_state  <= S_DONE;
                                end
                            end
                            OP_READ: begin
                                if (in_range(i_index_a)) begin
                                    r_state <= S_RR;
                                end else begin
                                    r_status <= ST_ZERO;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                // corner fetch
                S_GA: r_state <= S_GB;
                S_GB: begin
                    r_ga    <= geo_rdata;
                    r_state <= S_GC;
                end
                S_GC: begin
                    r_gb    <= geo_rdata;
                    r_state <= S_GD;
                end
                S_GD: begin
                    r_gc    <= geo_rdata;
                    r_state <= S_DLT;
                end
                // edges and UV deltas
                S_DLT: begin
                    r_du1 <= {r_gb.u[15], r_gb.u} - {r_ga.u[15], r_ga.u};
                    r_dv1 <= {r_gb.v[15], r_gb.v} - {r_ga.v[15], r_ga.v};
                    r_du2 <= {r_gc.u[15], r_gc.u} - {r_ga.u[15], r_ga.u};
                    r_dv2 <= {r_gc.v[15], r_gc.v} - {r_ga.v[15], r_ga.v};
                    r_e1[0] <= {r_gb.px[31], r_gb.px} - {r_ga.px[31], r_ga.px};
                    r_e1[1] <= {r_gb.py[31], r_gb.py} - {r_ga.py[31], r_ga.py};
                    r_e1[2] <= {r_gb.pz[31], r_gb.pz} - {r_ga.pz[31], r_ga.pz};
                    r_e2[0] <= {r_gc.px[31], r_gc.px} - {r_ga.px[31], r_ga.px};
                    r_e2[1] <= {r_gc.py[31], r_gc.py} - {r_ga.py[31], r_ga.py};
                    r_e2[2] <= {r_gc.pz[31], r_gc.pz} - {r_ga.pz[31], r_ga.pz};
                    r_state <= S_DETM;
                end
                S_DETM: begin
                    r_pd1   <= r_du1 * r_dv2;
                    r_pd2   <= r_du2 * r_dv1;
                    r_state <= S_DETS;
                end
                S_DETS: begin
                    r_det <= {r_pd1[34], r_pd1} - {r_pd2[34], r_pd2};
                    if (r_pd1 == r_pd2) begin
                        r_status <= ST_DEGEN;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_NUMM;
                    end
                end
                // numerators of one component
                S_NUMM: begin
                    r_p1    <= r_dv2 * e1k;
                    r_p2    <= r_dv1 * e2k;
                    r_p3    <= r_du1 * e2k;
                    r_p4    <= r_du2 * e1k;
                    r_state <= S_NUMS;
                end
                S_NUMS: begin
                    r_num_t <= {r_p1[49], r_p1} - {r_p2[49], r_p2};
                    r_num_b <= {r_p3[49], r_p3} - {r_p4[49], r_p4};
                    r_state <= S_QS;
                end
                S_QS: begin
                    r_qsat  <= qsat;
                    r_qneg  <= qnum[50] ^ r_det[35];
                    r_state <= S_QW;
                end
                S_QW: begin
                    if (div_done) begin
                        r_sat <= r_sat | r_qsat;
                        if (r_qsel) begin
                            r_b[r_k] <= r_qneg ? (48'd0 - {1'b0, qmag}) : {1'b0, qmag};
                            r_qsel   <= 1'b0;
                            if (r_k == 2'd2) begin
                                r_k     <= '0;
                                r_state <= S_AR;
                            end else begin
                                r_k     <= r_k + 2'd1;
                                r_state <= S_NUMM;
                            end
                        end else begin
                            r_t[r_k] <= r_qneg ? (48'd0 - {1'b0, qmag}) : {1'b0, qmag};
                            r_qsel   <= 1'b1;
                            r_state  <= S_QS;
                        end
                    end
                end
                // read-modify-write of each corner's sums
                S_AR: r_state <= S_AW;
                S_AW: begin
                    if (acc[0][SUM_W] || acc[1][SUM_W] || acc[2][SUM_W]
                            || acc[3][SUM_W] || acc[4][SUM_W] || acc[5][SUM_W]
                            || r_sat) begin
                        r_sat <= 1'b1;
                    end
                    if (r_k == 2'd2) begin
                        r_status <= (r_sat || acc[0][SUM_W] || acc[1][SUM_W]
                                  || acc[2][SUM_W] || acc[3][SUM_W]
                                  || acc[4][SUM_W] || acc[5][SUM_W]) ? ST_SAT : ST_OK;
                        r_state  <= S_DONE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_AR;
                    end
                end
                // read and normalize
                S_RR: r_state <= S_RC;
                S_RC: begin
                    r_sums  <= sum_rdata;
                    r_state <= S_NLD;
                end
                S_NLD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_na[i]   <= vsrc[i][SUM_W-1] ? (48'd0 - vsrc[i]) : vsrc[i];
                        r_nneg[i] <= vsrc[i][SUM_W-1];
                    end
                    r_k <= '0;
                    if ((vsrc[0] | vsrc[1] | vsrc[2]) == '0) begin
                        r_zero <= 1'b1;
                        if (r_vsel) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_DONE;
                        end else begin
                            r_vsel <= 1'b1;
                        end
                    end else begin
                        r_state <= S_NSH;
                    end
                end
                S_NSH: begin
                    priority if (sh_hi) begin
                        for (int i = 0; i < 3; i++) r_na[i] <= r_na[i] >> 1;
                    end else if (sh_lo) begin
                        for (int i = 0; i < 3; i++) r_na[i] <= r_na[i] << 1;
                    end else begin
                        r_state <= S_NSQ;
                    end
                end
                S_NSQ: begin
                    for (int i = 0; i < 3; i++) r_sq[i] <= r_na[i][29:0] * r_na[i][29:0];
                    r_state <= S_NSS;
                end
                S_NSS: begin
                    r_sn    <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
                    r_sres  <= '0;
                    r_sbit  <= SQ_BIT0;
                    r_state <= S_SQ;
                end
                // square root, one bit pair a cycle
                S_SQ: begin
                    if (r_sn >= sq_try) begin
                        r_sn   <= r_sn - sq_try;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit == SQ_W'(1)) r_state <= S_NDS;
                end
                S_NDS: r_state <= S_NDW;
                S_NDW: begin
                    if (div_done) begin
                        r_vec[vidx] <= r_nneg[r_k] ? (16'd0 - {1'b0, nq}) : {1'b0, nq};
                        if (r_k == 2'd2) begin
                            r_k <= '0;
                            if (r_vsel) begin
                                r_status <= r_zero ? ST_ZERO : ST_OK;
                                r_state  <= S_DONE;
                            end else begin
                                r_vsel  <= 1'b1;
                                r_state <= S_NLD;
                            end
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_NDS;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_tangent_x   = r_o_vec[0];
    assign o_tangent_y   = r_o_vec[1];
    assign o_tangent_z   = r_o_vec[2];
    assign o_bitangent_x = r_o_vec[3];
    assign o_bitangent_y = r_o_vec[4];
    assign o_bitangent_z = r_o_vec[5];

`ifndef SYNTHESIS
    // no item is taken while the sum RAM is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");

    // a divider result only arrives while the sequencer waits for one
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_QW || r_state == S_NDW))
        else $error("divider finished outside a wait state");

    // a sum write-back follows the read of the same corner
    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AW) |-> $past(r_state == S_AR))
        else $error("sum write-back without a preceding read");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mta_pkg::*;

    localparam longint SUM_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam int     WDOG_MAX  = 20000;
    localparam int     HOLD_LEN  = 3000;
    localparam int     N_RANDOM  = 1430;

    typedef struct {
        bit                  sync;   // wait until every result has come
        logic [1:0]          op;
        logic [IDX_W-1:0]    ia, ib, ic;
        logic signed [31:0]  px, py, pz;
        logic signed [15:0]  u, v;
    } vtx_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] tx, ty, tz, bx, by, bz;
    } frame_res_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_operation = '0;
    logic [IDX_W-1:0]   i_index_a = '0, i_index_b = '0, i_index_c = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0] i_tex_u = '0, i_tex_v = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [15:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic signed [15:0] o_bitangent_x, o_bitangent_y, o_bitangent_z;

    mesh_tangent_accumulator_top u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    longint     geo_px[VERTEX_COUNT], geo_py[VERTEX_COUNT], geo_pz[VERTEX_COUNT];
    longint     geo_u[VERTEX_COUNT], geo_v[VERTEX_COUNT];
    longint     acc_t[VERTEX_COUNT][3], acc_b[VERTEX_COUNT][3];
    bit         sat_hit;

    vtx_cmd_t   cmd_q[$];
    frame_res_t frame_exp_q[$];
    bit         loaded_gen[VERTEX_COUNT];
    int         loaded_list[$];

    bit         in_taken, out_taken;
    int         n_taken, n_done, n_errors, wdog;
    int         n_load, n_tri, n_read, n_degen, n_sat, n_zero;
    bit         idle_on, hold_done;
    int         hold_left;

    function automatic longint unsigned umag(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    // Q.28 numerator over Q.24 determinant, Q24.24 result, clamped
    function automatic longint div_q24(longint num, longint den);
        longint unsigned an, ad, q, r, m;
        an = umag(num);
        ad = umag(den);
        q = an / ad;
        r = an % ad;
        if (q >= (64'd1 << 27)) begin
            m = SUM_HI;
            sat_hit = 1'b1;
        end else begin
            m = (q << 20) + ((r << 20) / ad);
        end
        return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint acc_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) begin
            sat_hit = 1'b1;
            return SUM_HI;
        end
        if (s < SUM_LO) begin
            sat_hit = 1'b1;
            return SUM_LO;
        end
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // unit vector in Q2.14; returns 0 for a zero vector
    function automatic bit unit_vec(input longint s0, s1, s2,
                                    output logic [15:0] o0, o1, o2);
        longint          sv[3];
        longint unsigned a[3], m, l2, len, q;
        logic [15:0]     o[3];
        int              bl;
        sv[0] = s0; sv[1] = s1; sv[2] = s2;
        m = 0;
        l2 = 0;
        bl = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = umag(sv[i]);
            if (a[i] > m) m = a[i];
        end
        o0 = '0; o1 = '0; o2 = '0;
        if (m == 0) return 1'b0;
        while (bl < 64 && (m >> bl) != 0) bl++;
        for (int i = 0; i < 3; i++) begin
            a[i] = bl > 30 ? a[i] >> (bl - 30) : a[i] << (30 - bl);
            l2 += a[i] * a[i];
        end
        len = int_sqrt(l2);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 14) + len / 2) / len;
            o[i] = sv[i] < 0 ? 16'(longint'(0) - q) : q[15:0];
        end
        o0 = o[0]; o1 = o[1]; o2 = o[2];
        return 1'b1;
    endfunction

    // expected result of one accepted item; updates the vertex state
    function automatic frame_res_t predict_frame(vtx_cmd_t c);
        frame_res_t r;
        longint e1[3], e2[3], du1, dv1, du2, dv2, det, t[3], b[3];
        int     cn[3];
        bit     okt, okb;
        r = '0;
        case (c.op)
            OP_LOAD: begin
                geo_px[c.ia] = c.px; geo_py[c.ia] = c.py; geo_pz[c.ia] = c.pz;
                geo_u[c.ia] = c.u;   geo_v[c.ia] = c.v;
                for (int k = 0; k < 3; k++) begin
                    acc_t[c.ia][k] = 0;
                    acc_b[c.ia][k] = 0;
                end
                r.status = ST_OK;
            end
            OP_TRI: begin
                e1[0] = geo_px[c.ib] - geo_px[c.ia];
                e1[1] = geo_py[c.ib] - geo_py[c.ia];
                e1[2] = geo_pz[c.ib] - geo_pz[c.ia];
                e2[0] = geo_px[c.ic] - geo_px[c.ia];
                e2[1] = geo_py[c.ic] - geo_py[c.ia];
                e2[2] = geo_pz[c.ic] - geo_pz[c.ia];
                du1 = geo_u[c.ib] - geo_u[c.ia];
                dv1 = geo_v[c.ib] - geo_v[c.ia];
                du2 = geo_u[c.ic] - geo_u[c.ia];
                dv2 = geo_v[c.ic] - geo_v[c.ia];
                det = du1 * dv2 - du2 * dv1;
                if (det == 0) begin
                    r.status = ST_DEGEN;
                end else begin
                    sat_hit = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        t[k] = div_q24(dv2 * e1[k] - dv1 * e2[k], det);
                        b[k] = div_q24(du1 * e2[k] - du2 * e1[k], det);
                    end
                    cn[0] = int'(c.ia); cn[1] = int'(c.ib); cn[2] = int'(c.ic);
                    for (int j = 0; j < 3; j++) begin
                        for (int k = 0; k < 3; k++) begin
                            acc_t[cn[j]][k] = acc_sat(acc_t[cn[j]][k], t[k]);
                            acc_b[cn[j]][k] = acc_sat(acc_b[cn[j]][k], b[k]);
                        end
                    end
                    r.status = sat_hit ? ST_SAT : ST_OK;
                end
            end
            OP_READ: begin
                okt = unit_vec(acc_t[c.ia][0], acc_t[c.ia][1], acc_t[c.ia][2],
                               r.tx, r.ty, r.tz);
                okb = unit_vec(acc_b[c.ia][0], acc_b[c.ia][1], acc_b[c.ia][2],
                               r.bx, r.by, r.bz);
                r.status = (okt && okb) ? ST_OK : ST_ZERO;
            end
            default: r.status = ST_OK;
        endcase
        return r;
    endfunction

    task automatic add_cmd(logic [1:0] op, int a, int b, int c,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] u, logic [15:0] v);
        vtx_cmd_t m;
        m.sync = 1'b0;
        m.op = op; m.ia = IDX_W'(a); m.ib = IDX_W'(b); m.ic = IDX_W'(c);
        m.px = x; m.py = y; m.pz = z; m.u = u; m.v = v;
        if (op == OP_LOAD && !loaded_gen[a]) begin
            loaded_gen[a] = 1'b1;
            loaded_list = {loaded_list, a};
        end
        cmd_q = {cmd_q, m};
    endtask

    task automatic add_sync();
        vtx_cmd_t m;
        m = '{default: '0};
        m.sync = 1'b1;
        cmd_q = {cmd_q, m};
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 << 20)) - (1 << 20));
        endcase
    endfunction

    // stimulus: directed part, then random items
    initial begin
        int p, a, b, c;
        // edge positions and texture extremes
        add_cmd(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_LOAD, 1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                16'h7FFF, 16'h0000);
        add_cmd(OP_LOAD, 2, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                16'h0000, 16'h8000);
        add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);       // zero sums
        add_cmd(OP_TRI, 0, 1, 2, 0, 0, 0, 0, 0);
        add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_TRI, 0, 0, 1, 0, 0, 0, 0, 0);        // zero determinant
        add_cmd(OP_READ, 1023, 1023, 1023, 0, 0, 0, 0, 0);
        // unit right triangle
        add_cmd(OP_LOAD, 3, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_LOAD, 4, 0, 0, 32'h0001_0000, 0, 0, 16'h1000, 0);
        add_cmd(OP_LOAD, 5, 0, 0, 0, 32'h0001_0000, 0, 0, 16'h1000);
        add_cmd(OP_TRI, 3, 4, 5, 0, 0, 0, 0, 0);
        add_cmd(OP_READ, 4, 0, 0, 0, 0, 0, 0, 0);
        // tiny determinant with wide positions: quotient clamp
        add_cmd(OP_LOAD, 6, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
        add_cmd(OP_LOAD, 7, 0, 0, 32'h7FFF_FFFF, 0, 0, 16'h0001, 0);
        add_cmd(OP_LOAD, 8, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'h0001);
        add_cmd(OP_TRI, 6, 7, 8, 0, 0, 0, 0, 0);
        add_cmd(OP_TRI, 6, 7, 8, 0, 0, 0, 0, 0);
        add_cmd(OP_READ, 6, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(2'd3, 1023, 1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF, 16'hFFFF);
        add_cmd(OP_LOAD, 1023, 1023, 1023, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF,
                16'hFFFF, 16'h8000);
        add_cmd(OP_READ, 6, 0, 0, 0, 0, 0, 0, 0);
        add_sync();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 900) add_sync();
            p = $urandom_range(99);
            a = $urandom_range(3) != 0 ? $urandom_range(31) : $urandom_range(1023);
            b = $urandom_range(1023);
            c = $urandom_range(1023);
            if (p < 30 || loaded_list.size() < 3) begin
                add_cmd(OP_LOAD, a, b, c, rand_pos(), rand_pos(), rand_pos(),
                        $urandom_range(9) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(8192) - 4096),
                        $urandom_range(9) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(8192) - 4096));
            end else if (p < 65) begin
                // corners from vertices already loaded, sometimes repeated
                a = loaded_list[$urandom_range(loaded_list.size() - 1)];
                b = loaded_list[$urandom_range(loaded_list.size() - 1)];
                c = $urandom_range(9) == 0 ? a
                    : loaded_list[$urandom_range(loaded_list.size() - 1)];
                add_cmd(OP_TRI, a, b, c, $urandom, $urandom, $urandom,
                        16'($urandom), 16'($urandom));
            end else if (p < 96) begin
                add_cmd(OP_READ, a, b, c, $urandom, $urandom, $urandom,
                        16'($urandom), 16'($urandom));
            end else begin
                add_cmd(2'd3, a, b, c, $urandom, $urandom, $urandom,
                        16'($urandom), 16'($urandom));
            end
        end
    end

    // reset once, then wait for all stimulus and results
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (cmd_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (frame_exp_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        $display("covered %0d loads, %0d triangles, %0d reads", n_load, n_tri, n_read);
        $display("  %0d degenerate, %0d saturated, %0d zero-vector results; %0d errors",
                 n_degen, n_sat, n_zero, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // idling is switched off for a stretch in the middle of the run
    assign idle_on = !(n_taken >= 600 && n_taken < 800);

    // sender: next item at the falling edge after a transfer
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (cmd_q.size() != 0 && cmd_q[0].sync && frame_exp_q.size() == 0)
                void'(cmd_q.pop_front());
            if (cmd_q.size() != 0 && !cmd_q[0].sync
                && !(idle_on && $urandom_range(99) < 20)) begin
                i_operation <= cmd_q[0].op;
                i_index_a   <= cmd_q[0].ia;
                i_index_b   <= cmd_q[0].ib;
                i_index_c   <= cmd_q[0].ic;
                i_pos_x     <= cmd_q[0].px;
                i_pos_y     <= cmd_q[0].py;
                i_pos_z     <= cmd_q[0].pz;
                i_tex_u     <= cmd_q[0].u;
                i_tex_v     <= cmd_q[0].v;
                i_in_valid  <= 1'b1;
                void'(cmd_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!hold_done && n_taken >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_on && $urandom_range(99) < 20);
        end
    end

    // monitor: check result transfers, then predict input transfers
    always @(posedge i_clk) begin
        frame_res_t got, want;
        vtx_cmd_t   c;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (out_taken) begin
            got = '{o_status, o_tangent_x, o_tangent_y, o_tangent_z,
                    o_bitangent_x, o_bitangent_y, o_bitangent_z};
            n_done++;
            if (frame_exp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result %0d with nothing expected: %p", n_done, got);
            end else begin
                want = frame_exp_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result %0d mismatch: expected %p, got %p",
                                 n_done, want, got);
                end
            end
        end
        if (in_taken) begin
            c = '{1'b0, i_operation, i_index_a, i_index_b, i_index_c,
                  i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v};
            want = predict_frame(c);
            frame_exp_q = {frame_exp_q, want};
            n_taken++;
            case (c.op)
                OP_LOAD: n_load++;
                OP_TRI:  n_tri++;
                OP_READ: n_read++;
                default: ;
            endcase
            if (c.op == OP_TRI && want.status == ST_DEGEN) n_degen++;
            if (c.op == OP_TRI && want.status == ST_SAT)   n_sat++;
            if (c.op == OP_READ && want.status == ST_ZERO) n_zero++;
        end
        // watchdog on cycles without any transfer
        if (in_taken || out_taken) wdog = 0;
        else wdog++;
        if (wdog >= WDOG_MAX) begin
            $display("timeout after %0d idle cycles", wdog);
            $display("simulation failed");
            $finish;
        end
    end

endmodule

### mesh_tangent_accumulator_top.f
hdl/mta_pkg.sv
hdl/mta_ram.sv
hdl/mta_div.sv
hdl/mesh_tangent_accumulator_top.sv
test/tb_top.sv
